// ----- hw/rtl/tlmd_pkg.sv -----
// Shared types, result codes and defaults for the type-length message deframer.
package tlmd_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 16384;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int FATAL_ERRORS = 5;
  localparam int BYTE_BITS = 8;
  localparam int LEN_BITS = 16;
  localparam int TALLY_BITS = 3;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_EMPTY = 2'd1;
  localparam kind_t KIND_OVERSIZE = 2'd2;
  localparam kind_t KIND_FATAL = 2'd3;

  typedef struct packed {
    kind_t kind;
    logic [BYTE_BITS-1:0] msg_type;
    logic [BYTE_BITS-1:0] payload_byte;
    logic [LEN_BITS-1:0] payload_index;
    logic [LEN_BITS-1:0] msg_length;
    logic last;
  } result_t;

endpackage

// ----- hw/rtl/tlmd_front.sv -----
// Front part: parses header and payload bytes; each payload byte and each empty or oversized header gives a result.
module tlmd_front #(
  parameter int MAX_PAYLOAD = tlmd_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [tlmd_pkg::BYTE_BITS-1:0] in_byte,
  output logic res_valid,
  output tlmd_pkg::result_t res
);
  import tlmd_pkg::*;

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_LEN_HI = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;
  localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_PAYLOAD);
  localparam logic [TALLY_BITS-1:0] FATAL_TALLY = TALLY_BITS'(FATAL_ERRORS);

  logic [1:0] phase, phase_next;
  logic [BYTE_BITS-1:0] held_type, held_type_next;
  logic [BYTE_BITS-1:0] length_low, length_low_next;
  logic [LEN_BITS-1:0] declared_length, declared_length_next;
  logic [LEN_BITS-1:0] byte_position, byte_position_next;
  logic [TALLY_BITS-1:0] error_tally, error_tally_next;
  logic halted, halted_next;

  logic [LEN_BITS-1:0] new_length;
  logic [LEN_BITS:0] position_plus;
  logic fin;

  assign new_length = {in_byte, length_low};
  assign position_plus = {1'b0, byte_position} + (LEN_BITS+1)'(1);
  assign fin = position_plus >= {1'b0, declared_length};

  always_comb begin
    phase_next = phase;
    held_type_next = held_type;
    length_low_next = length_low;
    declared_length_next = declared_length;
    byte_position_next = byte_position;
    error_tally_next = error_tally;
    halted_next = halted;
    res_valid = 1'b0;
    res.kind = KIND_PAYLOAD;
    res.msg_type = held_type;
    res.payload_byte = '0;
    res.payload_index = '0;
    res.msg_length = declared_length;
    res.last = 1'b1;
    if (in_valid && !halted) begin
      unique case (phase)
        PH_TYPE: begin
          held_type_next = in_byte;
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_low_next = in_byte;
          phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          declared_length_next = new_length;
          byte_position_next = '0;
          res.msg_length = new_length;
          if (new_length > MAX_LEN) begin
            error_tally_next = error_tally + TALLY_BITS'(1);
            phase_next = PH_TYPE;
            res_valid = 1'b1;
            if (error_tally_next < FATAL_TALLY) begin
              res.kind = KIND_OVERSIZE;
            end else begin
              res.kind = KIND_FATAL;
              halted_next = 1'b1;
            end
          end else if (new_length == '0) begin
            phase_next = PH_TYPE;
            res_valid = 1'b1;
            res.kind = KIND_EMPTY;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          res.kind = KIND_PAYLOAD;
          res.payload_byte = in_byte;
          res.payload_index = byte_position;
          res.last = fin;
          if (fin) begin
            phase_next = PH_TYPE;
            byte_position_next = '0;
          end else begin
            byte_position_next = position_plus[LEN_BITS-1:0];
          end
        end
        default: begin
          phase_next = PH_TYPE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      held_type <= '0;
      length_low <= '0;
      declared_length <= '0;
      byte_position <= '0;
      error_tally <= '0;
      halted <= 1'b0;
    end else begin
      phase <= phase_next;
      held_type <= held_type_next;
      length_low <= length_low_next;
      declared_length <= declared_length_next;
      byte_position <= byte_position_next;
      error_tally <= error_tally_next;
      halted <= halted_next;
    end
  end

endmodule

// ----- hw/rtl/tlmd_queue.sv -----
// Short result queue that decouples the parser from the output stage.
module tlmd_queue #(
  parameter int DEPTH = tlmd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  tlmd_pkg::result_t wr_data,
  input  logic rd_en,
  output tlmd_pkg::result_t rd_data,
  output logic q_empty,
  output logic q_full
);
  import tlmd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr, do_rd;

  assign q_empty = count == '0;
  assign q_full = count == CNT_W'(DEPTH);
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/tlmd_back.sv -----
// Back part: output register that presents the oldest result until it is popped.
module tlmd_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  tlmd_pkg::result_t q_data,
  output logic q_take,
  input  logic pop,
  output logic empty,
  output tlmd_pkg::result_t out
);
  import tlmd_pkg::*;

  logic out_valid;

  assign empty = !out_valid;
  assign q_take = !q_empty && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (q_take) begin
      out <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/type_length_message_deframer_unit.sv -----
// Top level of the type-length message deframer: parser, result queue and output stage.
// Throughput is one byte per cycle while full is low; the parser takes every accepted byte.
// A result is queued at the edge that accepts its byte and then moves to the output register.
// Header bytes give a result only for a zero or oversized length; none after a fatal result.
// Reset is synchronous and clears the parser state, the error count, the queue and the output.
module type_length_message_deframer_unit #(
  parameter int MAX_PAYLOAD = tlmd_pkg::MAX_PAYLOAD_DEFAULT,
  parameter int QUEUE_DEPTH = tlmd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] rx_byte,
  output logic empty,
  input  logic pop,
  output logic [1:0] kind,
  output logic [7:0] msg_type,
  output logic [7:0] payload_byte,
  output logic [15:0] payload_index,
  output logic [15:0] msg_length,
  output logic last
);
  import tlmd_pkg::*;

  logic in_valid;
  logic res_valid;
  result_t res;
  result_t q_data;
  result_t out;
  logic q_empty, q_full, q_take;

  assign full = q_full;
  assign in_valid = push && !full;

  tlmd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_byte(rx_byte),
    .res_valid(res_valid),
    .res(res)
  );

  tlmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(res_valid),
    .wr_data(res),
    .rd_en(q_take),
    .rd_data(q_data),
    .q_empty(q_empty),
    .q_full(q_full)
  );

  tlmd_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_data(q_data),
    .q_take(q_take),
    .pop(pop),
    .empty(empty),
    .out(out)
  );

  assign kind = out.kind;
  assign msg_type = out.msg_type;
  assign payload_byte = out.payload_byte;
  assign payload_index = out.payload_index;
  assign msg_length = out.msg_length;
  assign last = out.last;

endmodule

// ----- hw/rtl/tlmd_checker.sv -----
// Port-level checks for the type-length message deframer, bound to its top level.
module tlmd_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic [1:0] kind,
  input logic [7:0] msg_type,
  input logic [7:0] payload_byte,
  input logic [15:0] payload_index,
  input logic [15:0] msg_length,
  input logic last
);
  import tlmd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result pending right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kind) && $stable(payload_byte)
      && $stable(payload_index) && $stable(last))
    else $error("Waiting result changed before it was taken.");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != KIND_PAYLOAD |-> last && payload_byte == '0 && payload_index == '0)
    else $error("Message end result is malformed.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == KIND_PAYLOAD |-> payload_index < msg_length)
    else $error("Payload index beyond declared length.");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == KIND_PAYLOAD && last |-> payload_index + 16'd1 == msg_length)
    else $error("Last payload byte at wrong index.");

endmodule

bind type_length_message_deframer_unit tlmd_checker u_tlmd_checker (
  .clk(clk),
  .rst(rst),
  .push(push),
  .full(full),
  .empty(empty),
  .pop(pop),
  .kind(kind),
  .msg_type(msg_type),
  .payload_byte(payload_byte),
  .payload_index(payload_index),
  .msg_length(msg_length),
  .last(last)
);

// ----- tb/sv/tb_type_length_message_deframer_unit.sv -----
// Self-checking testbench for the type-length message deframer with its own prediction.
module tb_type_length_message_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlmd_pkg::*;

  localparam int MAX_LEN = MAX_PAYLOAD_DEFAULT;
  localparam int LONG_LEN = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {
    WAIT_TYPE,
    WAIT_LEN_LOW,
    WAIT_LEN_HIGH,
    IN_PAYLOAD
  } frame_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] rx_byte = 8'h00;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] kind;
  logic [7:0] msg_type;
  logic [7:0] payload_byte;
  logic [15:0] payload_index;
  logic [15:0] msg_length;
  logic last;

  frame_phase_e frame_phase = WAIT_TYPE;
  logic [7:0] held_type = '0;
  logic [7:0] len_low = '0;
  logic [15:0] frame_length = '0;
  logic [15:0] frame_pos = '0;
  logic [2:0] oversize_count = '0;
  logic rx_halted = 1'b0;

  result_t expected_results[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  type_length_message_deframer_unit i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .msg_type(msg_type),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .msg_length(msg_length),
    .last(last)
  );

  always #10 clk = ~clk;

  function automatic result_t make_result(input kind_t k, input logic [7:0] pbyte,
                                          input logic [15:0] pindex, input logic fin);
    result_t r;
    r.kind = k;
    r.msg_type = held_type;
    r.payload_byte = pbyte;
    r.payload_index = pindex;
    r.msg_length = frame_length;
    r.last = fin;
    return r;
  endfunction

  function automatic void predict_deframe(input logic [7:0] b);
    logic fin;
    if (rx_halted) return;
    case (frame_phase)
      WAIT_TYPE: begin
        held_type = b;
        frame_phase = WAIT_LEN_LOW;
      end
      WAIT_LEN_LOW: begin
        len_low = b;
        frame_phase = WAIT_LEN_HIGH;
      end
      WAIT_LEN_HIGH: begin
        frame_length = {b, len_low};
        frame_pos = '0;
        frame_phase = WAIT_TYPE;
        if (int'(frame_length) > MAX_LEN) begin
          oversize_count = oversize_count + 3'd1;
          if (int'(oversize_count) < FATAL_ERRORS) begin
            expected_results.push_back(make_result(KIND_OVERSIZE, 8'h00, 16'h0000, 1'b1));
          end else begin
            rx_halted = 1'b1;
            expected_results.push_back(make_result(KIND_FATAL, 8'h00, 16'h0000, 1'b1));
          end
        end else if (frame_length == 16'h0000) begin
          expected_results.push_back(make_result(KIND_EMPTY, 8'h00, 16'h0000, 1'b1));
        end else begin
          frame_phase = IN_PAYLOAD;
        end
      end
      default: begin
        fin = (int'(frame_pos) + 1 >= int'(frame_length));
        expected_results.push_back(make_result(KIND_PAYLOAD, b, frame_pos, fin));
        frame_pos = frame_pos + 16'd1;
        if (fin) begin
          frame_phase = WAIT_TYPE;
          frame_pos = '0;
        end
      end
    endcase
  endfunction

  task automatic note_failure(input string what, input result_t want, input result_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected kind=%0d type=%02h byte=%02h index=%0d length=%0d last=%0b",
               $realtime, what, want.kind, want.msg_type, want.payload_byte,
               want.payload_index, want.msg_length, want.last);
      $display("%0t %s: actual   kind=%0d type=%02h byte=%02h index=%0d length=%0d last=%0b",
               $realtime, what, got.kind, got.msg_type, got.payload_byte,
               got.payload_index, got.msg_length, got.last);
    end
  endtask

  // Each transaction is sent from a falling edge and completes at a rising edge without full.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    predict_deframe(b);
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] mtype, input logic [15:0] mlen);
    send_byte(mtype);
    send_byte(mlen[7:0]);
    send_byte(mlen[15:8]);
  endtask

  task automatic send_message(input logic [7:0] mtype, input logic [15:0] mlen);
    send_header(mtype, mlen);
    if (int'(mlen) <= MAX_LEN) begin
      for (int i = 0; i < int'(mlen); i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_header(8'h00, 16'd0);
    send_header(8'hFF, 16'd1);
    send_byte(8'hFF);
    send_header(8'hA5, 16'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_header(8'h3C, 16'(MAX_LEN + 1));
    send_header(8'hC3, 16'hFFFF);
    send_header(8'h81, 16'd2);
    send_byte(8'h7E);
    send_byte(8'h81);
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int n_bytes);
    int start_count;
    int choice;
    int mlen;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = 0;
    while (start_count < n_bytes) begin
      choice = $urandom_range(99);
      if (choice < 90) begin
        choice = $urandom_range(99);
        if (choice < 15) mlen = 0;
        else if (choice < 75) mlen = $urandom_range(8, 1);
        else if (choice < 95) mlen = $urandom_range(64, 9);
        else mlen = $urandom_range(300, 65);
      end else if (oversize_count < 3'd3) begin
        mlen = $urandom_range(65535, MAX_LEN + 1);
      end else begin
        mlen = 0;
      end
      send_message(8'($urandom_range(255)), 16'(mlen));
      start_count += 3 + ((mlen <= MAX_LEN) ? mlen : 0);
    end
  endtask

  task automatic test_long_message();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_message(8'($urandom_range(255)), 16'(LONG_LEN));
  endtask

  task automatic test_fatal_halt();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    while (!rx_halted) begin
      send_header(8'($urandom_range(255)), 16'($urandom_range(65535, MAX_LEN + 1)));
    end
    send_header(8'h12, 16'd0);
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)));
  endtask

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (!rst && pop && !empty) begin
      seen = {kind, msg_type, payload_byte, payload_index, msg_length, last};
      if (expected_results.size() == 0) begin
        note_failure("unexpected result", '0, seen);
      end else begin
        want = expected_results.pop_front();
        if (seen.kind !== want.kind || seen.msg_type !== want.msg_type ||
            seen.payload_byte !== want.payload_byte ||
            seen.payload_index !== want.payload_index ||
            seen.msg_length !== want.msg_length || seen.last !== want.last) begin
          note_failure("result mismatch", want, seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** type_length_message_deframer_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_stream(37, 87, 200);
    test_random_stream(87, 37, 200);
    test_random_stream(0, 0, 200);
    test_long_message();
    test_fatal_halt();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** type_length_message_deframer_unit: PASSED **");
    end else begin
      $display("** type_length_message_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
